[rtl/ahl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ahl_pkg
// Shared types and constants of the ASCII-hex image loader.
// ---------------------------------------------------------------------------
package ahl_pkg;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_ADDR  = 3'd1,
    KIND_RAM   = 3'd2,
    KIND_FLASH = 3'd3,
    KIND_SKIP  = 3'd4,
    KIND_ENTRY = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DOLLAR = 3'd1,
    ST_NUM_A  = 3'd2,
    ST_NUM_E  = 3'd3,
    ST_SEP    = 3'd4,
    ST_NUM_D  = 3'd5
  } token_state_e;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;

  localparam logic [CfgIndexWidth-1:0] CFG_PROTECT_LOW  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_PROTECT_HIGH = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_FLASH_FIRST  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_FLASH_LAST   = 3'd3;

  localparam logic [31:0] PROTECT_LOW_RESET  = 32'h0000_03B0;
  localparam logic [31:0] PROTECT_HIGH_RESET = 32'h0000_0400;
  localparam logic [31:0] FLASH_FIRST_RESET  = 32'd4096000;
  localparam logic [31:0] FLASH_LAST_RESET   = 32'd4161535;

  localparam logic [31:0] LOAD_ADDRESS_RESET = 32'hFFFF_FFFF;

  localparam logic [7:0] CHAR_NULL   = 8'h00;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_E      = 8'h45;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_VT     = 8'h0B;
  localparam logic [7:0] CHAR_FF     = 8'h0C;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_SUB    = 8'h1A;
  localparam logic [7:0] CHAR_ALL1   = 8'hFF;

  typedef struct packed {
    logic [31:0] protect_low;
    logic [31:0] protect_high;
    logic [31:0] flash_first;
    logic [31:0] flash_last;
  } cfg_t;

  typedef struct packed {
    logic       is_null;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_space;
    logic       is_lf_cr;
    logic       is_dollar;
    logic       is_end;
    logic       is_a;
    logic       is_e;
  } char_class_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] target_address;
    logic [31:0] value;
    logic        end_mark;
  } result_t;

endpackage
`default_nettype wire

[rtl/ahl_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ahl_text_if / ahl_result_if
// Valid/ready channels for image characters and loader results.
// ---------------------------------------------------------------------------
interface ahl_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface ahl_result_if;
  logic                valid;
  logic                ready;
  ahl_pkg::kind_e      kind;
  logic [31:0]         target_address;
  logic [31:0]         value;
  logic                end_mark;

  modport source (output valid, output kind, output target_address, output value,
                  output end_mark, input ready);
  modport sink   (input valid, input kind, input target_address, input value,
                  input end_mark, output ready);
endinterface
`default_nettype wire

[rtl/ahl_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ahl_cfg_regs
// Address-range registers: protected window and flash window.
// ---------------------------------------------------------------------------
module ahl_cfg_regs (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire [ahl_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  wire [ahl_pkg::CfgDataWidth-1:0]      cfg_data_i,
  output ahl_pkg::cfg_t                        cfg_o
);

  ahl_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protect_low  <= ahl_pkg::PROTECT_LOW_RESET;
      cfg_q.protect_high <= ahl_pkg::PROTECT_HIGH_RESET;
      cfg_q.flash_first  <= ahl_pkg::FLASH_FIRST_RESET;
      cfg_q.flash_last   <= ahl_pkg::FLASH_LAST_RESET;
    end else if (cfg_we_i) begin
      // drop writes to unused indexes
      case (cfg_index_i)
        ahl_pkg::CFG_PROTECT_LOW:  cfg_q.protect_low  <= cfg_data_i;
        ahl_pkg::CFG_PROTECT_HIGH: cfg_q.protect_high <= cfg_data_i;
        ahl_pkg::CFG_FLASH_FIRST:  cfg_q.flash_first  <= cfg_data_i;
        ahl_pkg::CFG_FLASH_LAST:   cfg_q.flash_last   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[rtl/ahl_char_class.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ahl_char_class
// Decodes one image character into hex digit and separator flags.
// ---------------------------------------------------------------------------
module ahl_char_class (
  input  wire [7:0]             char_i,
  output ahl_pkg::char_class_t  class_o
);

  logic       is_dec, is_lo, is_up;
  logic [7:0] dec_off, lo_off, up_off;

  always_comb begin
    is_dec  = (char_i >= 8'h30) && (char_i <= 8'h39);
    is_lo   = (char_i >= 8'h61) && (char_i <= 8'h66);
    is_up   = (char_i >= 8'h41) && (char_i <= 8'h46);
    dec_off = char_i - 8'h30;
    lo_off  = char_i - 8'h57;
    up_off  = char_i - 8'h37;

    class_o.is_null   = (char_i == ahl_pkg::CHAR_NULL);
    class_o.is_hex    = is_dec || is_lo || is_up;
    class_o.hex_val   = is_dec ? dec_off[3:0] : (is_lo ? lo_off[3:0] : up_off[3:0]);
    class_o.is_space  = (char_i == ahl_pkg::CHAR_SPACE) || (char_i == ahl_pkg::CHAR_TAB) ||
                        (char_i == ahl_pkg::CHAR_LF)    || (char_i == ahl_pkg::CHAR_VT)  ||
                        (char_i == ahl_pkg::CHAR_FF)    || (char_i == ahl_pkg::CHAR_CR);
    class_o.is_lf_cr  = (char_i == ahl_pkg::CHAR_LF) || (char_i == ahl_pkg::CHAR_CR);
    class_o.is_dollar = (char_i == ahl_pkg::CHAR_DOLLAR);
    class_o.is_end    = (char_i == ahl_pkg::CHAR_SUB) || (char_i == ahl_pkg::CHAR_ALL1);
    class_o.is_a      = (char_i == ahl_pkg::CHAR_A);
    class_o.is_e      = (char_i == ahl_pkg::CHAR_E);
  end

endmodule
`default_nettype wire

[rtl/ahl_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ahl_parser
// Token state machine, hex accumulator and load address; forms one result
// per character and updates its state when the character advances.
// ---------------------------------------------------------------------------
module ahl_parser #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        advance_i,
  input  wire ahl_pkg::char_class_t  class_i,
  input  wire ahl_pkg::cfg_t         cfg_i,
  output ahl_pkg::result_t           result_o
);

  ahl_pkg::token_state_e   state_q, state_d;
  logic [NUMBER_WIDTH-1:0] acc_q, acc_d;
  logic                    digits_q, digits_d;
  logic [31:0]             load_addr_q, load_addr_d;
  logic                    addr_known_q, addr_known_d;

  logic [31:0]             acc32;
  logic                    do_commit, do_sep, allow_data;
  logic                    in_protect, in_flash;

  if (NUMBER_WIDTH >= 32) begin : g_acc_wide
    assign acc32 = acc_q[31:0];
  end else begin : g_acc_narrow
    assign acc32 = {{(32 - NUMBER_WIDTH){1'b0}}, acc_q};
  end

  assign in_protect = (load_addr_q >= cfg_i.protect_low) && (load_addr_q < cfg_i.protect_high);
  assign in_flash   = (load_addr_q >= cfg_i.flash_first) && (load_addr_q <= cfg_i.flash_last);

  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    digits_d     = digits_q;
    load_addr_d  = load_addr_q;
    addr_known_d = addr_known_q;
    do_commit    = 1'b0;
    do_sep       = 1'b0;
    allow_data   = 1'b0;

    result_o.kind           = ahl_pkg::KIND_NONE;
    result_o.target_address = '0;
    result_o.value          = '0;
    result_o.end_mark       = 1'b0;

    if (!class_i.is_null) begin
      case (state_q)
        ahl_pkg::ST_IDLE: begin
          if (class_i.is_dollar) state_d = ahl_pkg::ST_DOLLAR;
        end
        ahl_pkg::ST_DOLLAR: begin
          if (class_i.is_a || class_i.is_e) begin
            state_d  = class_i.is_a ? ahl_pkg::ST_NUM_A : ahl_pkg::ST_NUM_E;
            acc_d    = '0;
            digits_d = 1'b0;
          end else begin
            state_d = ahl_pkg::ST_IDLE;
          end
        end
        ahl_pkg::ST_NUM_A, ahl_pkg::ST_NUM_E, ahl_pkg::ST_NUM_D: begin
          if (class_i.is_hex) begin
            acc_d    = {acc_q[NUMBER_WIDTH-5:0], class_i.hex_val};
            digits_d = 1'b1;
          end else if (digits_q) begin
            do_commit  = 1'b1;
            do_sep     = 1'b1;
            allow_data = 1'b1;
          end else if (!class_i.is_space) begin
            // no digits yet: abandon the number
            do_sep = 1'b1;
          end
        end
        ahl_pkg::ST_SEP: begin
          do_sep     = 1'b1;
          allow_data = 1'b1;
        end
        default: state_d = ahl_pkg::ST_IDLE;
      endcase
    end

    if (do_commit) begin
      case (state_q)
        ahl_pkg::ST_NUM_A: begin
          load_addr_d             = acc32;
          addr_known_d            = 1'b1;
          result_o.kind           = ahl_pkg::KIND_ADDR;
          result_o.target_address = acc32;
        end
        ahl_pkg::ST_NUM_E: begin
          result_o.kind  = ahl_pkg::KIND_ENTRY;
          result_o.value = acc32;
        end
        default: begin
          if (in_protect)    result_o.kind = ahl_pkg::KIND_SKIP;
          else if (in_flash) result_o.kind = ahl_pkg::KIND_FLASH;
          else               result_o.kind = ahl_pkg::KIND_RAM;
          result_o.target_address = load_addr_q;
          result_o.value          = {16'h0000, acc32[15:0]};
          load_addr_d             = load_addr_q + 32'd1;
        end
      endcase
    end

    // separator handling sees the address state left by the commit
    if (do_sep) begin
      state_d = ahl_pkg::ST_SEP;
      if (class_i.is_lf_cr) begin
        state_d = ahl_pkg::ST_SEP;
      end else if (class_i.is_dollar) begin
        state_d = ahl_pkg::ST_DOLLAR;
      end else if (class_i.is_end) begin
        result_o.end_mark = 1'b1;
      end else if (allow_data && addr_known_d) begin
        acc_d    = '0;
        digits_d = 1'b0;
        if (class_i.is_hex) begin
          acc_d    = {{(NUMBER_WIDTH - 4){1'b0}}, class_i.hex_val};
          digits_d = 1'b1;
          state_d  = ahl_pkg::ST_NUM_D;
        end else if (class_i.is_space) begin
          state_d = ahl_pkg::ST_NUM_D;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ahl_pkg::ST_IDLE;
      acc_q        <= '0;
      digits_q     <= 1'b0;
      load_addr_q  <= ahl_pkg::LOAD_ADDRESS_RESET;
      addr_known_q <= 1'b0;
    end else if (advance_i) begin
      state_q      <= state_d;
      acc_q        <= acc_d;
      digits_q     <= digits_d;
      load_addr_q  <= load_addr_d;
      addr_known_q <= addr_known_d;
    end
  end

endmodule
`default_nettype wire

[rtl/ascii_hex_image_loader.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ascii_hex_image_loader
// Parses an ASCII-hex image one character per beat into load results.
// ---------------------------------------------------------------------------
// Usage:
//   text_i carries one image character per beat; result_o returns exactly one
//   beat per character: kind (none, address set, RAM write, flash write,
//   protected skip, entry), target address, value and end mark.
//   The cfg_* port writes the protected and flash address windows; write it
//   only while no character is in flight.
// Timing:
//   A character accepted lands in the input register; its result is
//   formed from the parser state and captured in the result register, from
//   which it is offered. One character per cycle is sustained while result_o
//   is not stalled: the parser update is a 4-bit shift-in, two 32-bit window
//   checks and a 32-bit address increment between the two registers.
// Reset:
//   Both pipeline registers empty, parser searching for '$', load address
//   unknown, address windows at their defaults.
// Stall:
//   While result_o is stalled the result register holds; the input register
//   still takes one more character, then text_i.ready drops until the result
//   beat is taken.
// ---------------------------------------------------------------------------
module ascii_hex_image_loader #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  ahl_text_if.sink                           text_i,
  ahl_result_if.source                       result_o,
  input  wire                                cfg_we_i,
  input  wire [ahl_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  wire [ahl_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 out_valid_q;
  ahl_pkg::result_t     out_q;
  ahl_pkg::result_t     result_d;
  ahl_pkg::cfg_t        cfg;
  ahl_pkg::char_class_t char_class;
  logic                 out_free, advance;

  assign out_free     = !out_valid_q || result_o.ready;
  assign advance      = in_valid_q && out_free;
  assign text_i.ready = !in_valid_q || out_free;

  ahl_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ahl_char_class u_char_class (
    .char_i  (in_byte_q),
    .class_o (char_class)
  );

  ahl_parser #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .class_i   (char_class),
    .cfg_i     (cfg),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (text_i.ready) begin
      in_valid_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.ready && text_i.valid) begin
      in_byte_q <= text_i.text_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  // hold the result beat while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.kind           = out_q.kind;
  assign result_o.target_address = out_q.target_address;
  assign result_o.value          = out_q.value;
  assign result_o.end_mark       = out_q.end_mark;

endmodule
`default_nettype wire
